// ===== design/drs_pkg.sv =====
// Package: shared constants, types and codes of the disk request scheduler.
`timescale 1ns / 1ps
package drs_pkg;
  localparam int QueueDepth = 64;
  localparam int SlotW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam int EntryW = 64;

  localparam logic [1:0] StAdded = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StServed = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  localparam logic [2:0] PolFcfs = 3'd0;
  localparam logic [2:0] PolSstf = 3'd1;
  localparam logic [2:0] PolScan = 3'd2;
  localparam logic [2:0] PolCscan = 3'd3;
  localparam logic [2:0] PolDeadline = 3'd4;

  localparam logic [1:0] RegPolicy = 2'd0;
  localparam logic [1:0] RegDeadline = 2'd1;
  localparam logic [1:0] RegLastCyl = 2'd2;

  // compare unit modes
  localparam logic [2:0] CmpOldest = 3'd0;
  localparam logic [2:0] CmpSucc = 3'd1;
  localparam logic [2:0] CmpPred = 3'd2;
  localparam logic [2:0] CmpExpired = 3'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_COMMIT, S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [15:0] served_cylinder;
    logic [15:0] served_id;
    logic [17:0] seek_distance;
    logic [15:0] head_after;
    logic [6:0] pending_after;
  } result_t;
endpackage

// ===== design/drs_if.sv =====
// Interfaces: request, result and configuration channels.
`timescale 1ns / 1ps
interface drs_req_if;
  logic valid;
  logic ready;
  logic action;
  logic [15:0] req_cylinder;
  logic [15:0] req_id;
  logic [31:0] arrive_tick;
  logic [31:0] now;
  modport source (output valid, action, req_cylinder, req_id, arrive_tick, now,
                  input ready);
  modport sink (input valid, action, req_cylinder, req_id, arrive_tick, now,
                output ready);
endinterface

interface drs_res_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [15:0] served_cylinder;
  logic [15:0] served_id;
  logic [17:0] seek_distance;
  logic [15:0] head_after;
  logic [6:0] pending_after;
  modport source (output valid, status, served_cylinder, served_id, seek_distance,
                  head_after, pending_after, input ready);
  modport sink (input valid, status, served_cylinder, served_id, seek_distance,
                head_after, pending_after, output ready);
endinterface

interface drs_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/drs_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module drs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0] wdata,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];

  // write or read one word a cycle
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== design/drs_cmp.sv =====
// Shared compare unit: tests one slot against the running best.
`timescale 1ns / 1ps
module drs_cmp (
  input  logic [2:0] mode,     // oldest, succ, pred or expired
  input  logic [15:0] lim,
  input  logic [31:0] now,
  input  logic [31:0] deadline_limit,
  input  logic have_best,
  input  logic [15:0] cyl,
  input  logic [15:0] id,
  input  logic [31:0] arr,
  input  logic [15:0] best_cyl,
  input  logic [15:0] best_id,
  input  logic [31:0] best_arr,
  output logic take
);
  import drs_pkg::*;

  logic [31:0] key, bkey, age;
  logic elig, better;

  assign key = {cyl, id};
  assign bkey = {best_cyl, best_id};
  assign age = now - arr;

  // qualify the slot, then order against the best so far
  always_comb begin
    elig = 1'b1;
    better = 1'b0;
    case (mode)
      CmpOldest: better = (arr < best_arr) || ((arr == best_arr) && (id < best_id));
      CmpSucc: begin elig = (cyl >= lim); better = key < bkey; end
      CmpPred: begin elig = (cyl < lim); better = key > bkey; end
      CmpExpired: begin elig = (age >= deadline_limit); better = key < bkey; end
      default: better = 1'b0;
    endcase
    take = elig && (!have_best || better);
  end
endmodule

// ===== design/disk_request_scheduler_core.sv =====
// Top level: disk request scheduler with slot table, scan sequencer and result register.
//
// Channels: req (sink) carries add and serve items, res (source) returns one
// result word per item, cfg (sink) writes policy_mode, deadline_limit and
// last_cylinder by index 0..2 while the block is idle.
// A scan reads the slot table one slot per cycle through the single RAM port
// into one shared compare unit; a drain state then takes in the last word read.
// An add or an empty serve needs no scan: the item passes from idle through
// decide and commit to the output state, and the next item waits for idle.
// A serve runs its scans before the commit: FCFS, SCAN and C-SCAN with a hit and
// DEADLINE with an expired request take one scan; SSTF, SCAN reversal and
// C-SCAN wrap take two; DEADLINE miss takes three.
// One item is in work at a time; req.ready is high only when idle.
// Reset clears the valid bits, head (0), sweep direction (up), pending count
// and the registers to their defaults; the table needs no clearing pass.
// The result is held in an output register until res.ready; no new item is
// taken before the result word leaves.
`timescale 1ns / 1ps
module disk_request_scheduler_core (
  input logic clk,
  input logic rst,
  drs_req_if.sink req,
  drs_res_if.source res,
  drs_cfg_if.sink cfg
);
  import drs_pkg::*;

  state_t state, state_next;
  logic [2:0] policy_mode;
  logic [31:0] deadline_limit;
  logic [15:0] last_cylinder;
  logic [QueueDepth-1:0] slot_valid;
  logic [15:0] head_cyl;
  logic sweep_up;
  logic [CntW-1:0] pending_total;

  logic action;
  logic [15:0] in_cyl, in_id;
  logic [31:0] in_arr, in_now;

  logic [CntW-1:0] idx;          // scan address counter
  logic [SlotW-1:0] rd_slot;     // slot of the word now on rdata
  logic rd_live;
  logic [2:0] cmode;
  logic [15:0] lim;
  logic [1:0] pass;              // which scan of this serve
  logic have_best;
  logic [SlotW-1:0] best_slot;
  logic [15:0] best_cyl, best_id;
  logic [31:0] best_arr;
  logic have_a;                  // below-head scan result kept for sstf and deadline
  logic [15:0] a_cyl, a_id;
  logic [SlotW-1:0] a_slot;
  logic wrap;
  logic [17:0] seek_pre;
  logic [15:0] head_pre;
  result_t rslt;
  logic need_scan;

  logic ram_we;
  logic [SlotW-1:0] ram_addr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  logic take;

  logic [SlotW-1:0] free_slot;
  logic free_found;

  // lowest free slot from the valid bits
  always_comb begin
    free_slot = '0;
    free_found = 1'b0;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_slot = SlotW'(i);
        free_found = 1'b1;
      end
    end
  end

  drs_ram #(.Width(EntryW), .Depth(QueueDepth)) u_table (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign ram_we = (state == S_COMMIT) && !action && free_found;
  assign ram_addr = (state == S_COMMIT) ? free_slot : idx[SlotW-1:0];
  assign ram_wdata = {in_cyl, in_id, in_arr};

  drs_cmp u_cmp (
    .mode(cmode), .lim(lim), .now(in_now), .deadline_limit(deadline_limit),
    .have_best(have_best),
    .cyl(ram_rdata[63:48]), .id(ram_rdata[47:32]), .arr(ram_rdata[31:0]),
    .best_cyl(best_cyl), .best_id(best_id), .best_arr(best_arr), .take(take)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = (state == S_IDLE);
  assign res.valid = (state == S_OUT);
  assign res.status = rslt.status;
  assign res.served_cylinder = rslt.served_cylinder;
  assign res.served_id = rslt.served_id;
  assign res.seek_distance = rslt.seek_distance;
  assign res.head_after = rslt.head_after;
  assign res.pending_after = rslt.pending_after;

  // decide whether another scan is due after this one
  always_comb begin
    need_scan = 1'b0;
    if (action && pending_total != '0) begin
      if (pass == 2'd0) need_scan = 1'b1;
      else if (pass == 2'd1) begin
        if (policy_mode == PolSstf) need_scan = 1'b1;
        else if (policy_mode == PolDeadline) need_scan = (cmode == CmpPred) || !have_best;
        else if (policy_mode == PolScan || policy_mode == PolCscan) need_scan = !have_best;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.valid) state_next = S_DECIDE;
      S_SCAN: if (idx == CntW'(QueueDepth - 1)) state_next = S_DRAIN;
      S_DRAIN: state_next = S_DECIDE;
      S_DECIDE: state_next = need_scan ? S_SCAN : S_COMMIT;
      S_COMMIT: state_next = S_OUT;
      S_OUT: if (res.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode <= PolFcfs;
      deadline_limit <= 32'd50;
      last_cylinder <= 16'hFFFF;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        RegPolicy: policy_mode <= cfg.data[2:0];
        RegDeadline: deadline_limit <= cfg.data;
        RegLastCyl: last_cylinder <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  logic [16:0] dist_a, dist_b;
  logic [16:0] leg1, leg2;
  assign dist_a = {1'b0, head_cyl} - {1'b0, a_cyl};
  assign dist_b = {1'b0, best_cyl} - {1'b0, head_cyl};
  assign leg1 = (last_cylinder >= head_cyl) ? {1'b0, last_cylinder - head_cyl}
                                            : {1'b0, head_cyl - last_cylinder};
  assign leg2 = {1'b0, last_cylinder};

  // sequencer: scans, decisions and commit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      slot_valid <= '0;
      head_cyl <= '0;
      sweep_up <= 1'b1;
      pending_total <= '0;
      rd_live <= 1'b0;
    end else begin
      state <= state_next;
      rd_live <= (state == S_SCAN);
      rd_slot <= idx[SlotW-1:0];
      if (rd_live && slot_valid[rd_slot] && take) begin
        have_best <= 1'b1;
        best_slot <= rd_slot;
        best_cyl <= ram_rdata[63:48];
        best_id <= ram_rdata[47:32];
        best_arr <= ram_rdata[31:0];
      end
      unique case (state)
        S_IDLE: if (req.valid) begin
          action <= req.action;
          in_cyl <= req.req_cylinder;
          in_id <= req.req_id;
          in_arr <= req.arrive_tick;
          in_now <= req.now;
          pass <= 2'd0;
          have_a <= 1'b0;
          wrap <= 1'b0;
          seek_pre <= '0;
          head_pre <= head_cyl;
          lim <= head_cyl;
          have_best <= 1'b0;
          idx <= '0;
        end
        S_SCAN: idx <= idx + 1'b1;
        S_DRAIN: ;
        S_DECIDE: begin
          // start the next scan, or settle the pick
          if (need_scan) begin
            idx <= '0;
            have_best <= 1'b0;
            if (pass == 2'd0) begin
              pass <= 2'd1;
              if (policy_mode == PolSstf) cmode <= CmpPred;
              else if (policy_mode == PolScan) cmode <= sweep_up ? CmpSucc : CmpPred;
              else if (policy_mode == PolCscan) cmode <= CmpSucc;
              else if (policy_mode == PolDeadline) cmode <= CmpExpired;
              else cmode <= CmpOldest;
            end else if (policy_mode == PolDeadline && cmode == CmpExpired) begin
              // nothing expired: fall back to nearest, below the head first
              cmode <= CmpPred;
            end else if (policy_mode == PolSstf || policy_mode == PolDeadline) begin
              // keep the best below the head, then look at or above it
              have_a <= have_best;
              a_cyl <= best_cyl; a_id <= best_id; a_slot <= best_slot;
              cmode <= CmpSucc;
              pass <= 2'd2;
            end else if (policy_mode == PolScan) begin
              // nothing ahead: reverse the sweep
              sweep_up <= ~sweep_up;
              cmode <= (cmode == CmpSucc) ? CmpPred : CmpSucc;
              pass <= 2'd2;
            end else begin
              // nothing at or above the head: travel to the far end, then zero
              wrap <= 1'b1;
              seek_pre <= 18'(leg1) + 18'(leg2);
              head_pre <= 16'd0;
              lim <= 16'd0;
              pass <= 2'd2;
            end
          end else if (pass == 2'd2 && have_a && (!have_best || dist_a <= dist_b)) begin
            // sstf and deadline fallback: the lower side wins when nearer or equally near
            have_best <= 1'b1;
            best_cyl <= a_cyl; best_id <= a_id; best_slot <= a_slot;
          end
        end
        S_COMMIT: begin
          rslt.served_cylinder <= '0;
          rslt.served_id <= '0;
          rslt.seek_distance <= '0;
          rslt.head_after <= head_cyl;
          rslt.pending_after <= 7'(pending_total);
          if (!action) begin
            if (free_found) begin
              slot_valid[free_slot] <= 1'b1;
              pending_total <= pending_total + 1'b1;
              rslt.pending_after <= 7'(pending_total + 1'b1);
              rslt.status <= StAdded;
            end else rslt.status <= StFull;
          end else if (pending_total == '0 || !have_best) begin
            rslt.status <= StEmpty;
          end else begin
            slot_valid[best_slot] <= 1'b0;
            pending_total <= pending_total - 1'b1;
            head_cyl <= best_cyl;
            if (policy_mode == PolCscan) sweep_up <= 1'b1;
            else if (best_cyl > head_pre) sweep_up <= 1'b1;
            else if (best_cyl < head_pre) sweep_up <= 1'b0;
            else if (wrap) sweep_up <= 1'b0;
            rslt.status <= StServed;
            rslt.served_cylinder <= best_cyl;
            rslt.served_id <= best_id;
            rslt.seek_distance <= seek_pre + 18'((best_cyl >= head_pre) ?
                                  best_cyl - head_pre : head_pre - best_cyl);
            rslt.head_after <= best_cyl;
            rslt.pending_after <= 7'(pending_total - 1'b1);
          end
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

  // the pending count tracks the valid bits
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(slot_valid) == int'(pending_total)))
    else $error("pending count mismatch");
  // an item is never taken while a result is held
  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !req.ready) else $error("input taken while result held");
  // a served result leaves the count below the queue depth
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && rslt.status == StServed) |-> (int'(rslt.pending_after) < QueueDepth))
    else $error("served with full count");
endmodule
